FILE: hw/rtl/sha256_byte_stream_hasher_unit_assert.svh
// Assertion macros for the SHA-256 byte stream hasher (clk / arst_n in scope).
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SBH_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sha256 hasher: implication check failed");

// Next-cycle implication, disabled while in reset
`define SBH_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sha256 hasher: next-cycle check failed");

`endif

FILE: hw/rtl/sha256_bsh_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package sha256_bsh_pkg;

	// Eight working words, element 0 is word a / hash word 0
	typedef logic [0:7][31:0] word_vec_t;
	// Sixteen-word schedule window, element 0 is the current round word
	typedef logic [0:15][31:0] blk_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] data;
		logic       start;
		logic       init;
	} cmp_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cmp_stat_t;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_FILL = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;

	localparam word_vec_t SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

FILE: hw/rtl/sha256_bsh_byte_if.sv
// Valid/ready channel carrying one message byte beat.
interface sha256_bsh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_valid;
	logic       message_end;

	modport source (output valid, msg_byte, byte_valid, message_end, input ready);
	modport sink (input valid, msg_byte, byte_valid, message_end, output ready);
endinterface

FILE: hw/rtl/sha256_bsh_digest_if.sv
// Valid/ready channel carrying one 64-bit digest part beat.
interface sha256_bsh_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_part;
	logic [1:0]  part_index;
	logic        last_part;

	modport source (output valid, digest_part, part_index, last_part, input ready);
	modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface

FILE: hw/rtl/sha256_bsh_round.sv
// One SHA-256 round and one message schedule step, shared by all 64 rounds.
module sha256_bsh_round
	import sha256_bsh_pkg::*;
(
	input  word_vec_t   v,
	input  blk_t        win,
	input  logic [31:0] k,
	output word_vec_t   v_next,
	output logic [31:0] w_next
);

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	// Compression round on the working words
	assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
	assign t1  = v[7] + big_sig1(v[4]) + ch + k + win[0];
	assign t2  = big_sig0(v[0]) + maj;

	assign v_next = {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};

	// Next schedule word from the sixteen-word window
	assign w_next = win[0] + sml_sig0(win[1]) + win[9] + sml_sig1(win[14]);

endmodule

FILE: hw/rtl/sha256_bsh_compress.sv
// Block buffer, hash words and the round sequencer of the compression.
module sha256_bsh_compress
	import sha256_bsh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmp_ctrl_t ctrl,
	output cmp_stat_t stat,
	output word_vec_t hash
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROUND,
		C_ADD
	} cmp_state_t;

	cmp_state_t  state_q;
	logic [5:0]  rnd_q;
	word_vec_t   hash_q;
	word_vec_t   v_q;
	logic [511:0] blk_q;
	blk_t        win;
	word_vec_t   v_next;
	logic [31:0] w_next;

	assign win = blk_q;

	sha256_bsh_round u_round (
		.v      (v_q),
		.win    (win),
		.k      (SHA_K[rnd_q]),
		.v_next (v_next),
		.w_next (w_next)
	);

	// Sequence 64 rounds, then fold the working words into the hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			hash_q  <= SHA_IV;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.init) begin
						hash_q <= SHA_IV;
					end
					if (ctrl.start) begin
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_RND) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Load working words, shift bytes in, advance the schedule window
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctrl.start) begin
			v_q <= hash_q;
		end else if (state_q == C_ROUND) begin
			v_q <= v_next;
		end
		if (ctrl.shift) begin
			blk_q <= {blk_q[503:0], ctrl.data};
		end else if (state_q == C_ROUND) begin
			blk_q <= {blk_q[479:0], w_next};
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = (state_q == C_ADD);
	assign hash      = hash_q;

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher_unit.sv
// A data byte is taken while idle; a byte that fills a block starts a compression, and no
// byte is taken until it is done. A message end adds padding bytes, one or two compressions
// and a digest load, which waits while the previous digest is still draining.
// Speed is set by the single round unit doing one round per cycle; bytes are not taken
// while a block is compressed, and the digest drains in 4 beats.
// Reset: asynchronous, active low; hash words return to the initial values, counts clear.
module sha256_byte_stream_hasher_unit
	import sha256_bsh_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	sha256_bsh_byte_if.sink            byte_in,
	sha256_bsh_digest_if.source        digest_out
);

	`include "sha256_byte_stream_hasher_unit_assert.svh"

	typedef enum logic [2:0] {
		T_IDLE,
		T_PAD80,
		T_ZERO,
		T_LEN,
		T_START,
		T_WAIT,
		T_DIGEST
	} top_state_t;

	top_state_t        state_q;
	top_state_t        ret_q;
	logic [5:0]        fill_q;
	logic [63:0]       bits_q;
	logic              obusy_q;
	logic [1:0]        part_q;
	logic [0:3][63:0]  dig_q;
	logic              in_acc;
	logic              out_acc;
	cmp_ctrl_t         ctrl;
	cmp_stat_t         stat;
	word_vec_t         hash;

	sha256_bsh_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.hash   (hash)
	);

	assign byte_in.ready = (state_q == T_IDLE);
	assign in_acc        = byte_in.valid && byte_in.ready;
	assign out_acc       = digest_out.valid && digest_out.ready;

	// Drive the byte path and compression controls
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			T_IDLE: begin
				ctrl.shift = in_acc && byte_in.byte_valid;
				ctrl.data  = byte_in.msg_byte;
			end
			T_PAD80: begin
				ctrl.shift = 1'b1;
				ctrl.data  = PAD_BYTE;
			end
			T_ZERO:   ctrl.shift = (fill_q != LEN_POS);
			T_LEN: begin
				ctrl.shift = 1'b1;
				ctrl.data  = bits_q[63:56];
			end
			T_START:  ctrl.start = 1'b1;
			T_WAIT:   ctrl.start = 1'b0;
			T_DIGEST: ctrl.init = !obusy_q;
			default:  ctrl = '0;
		endcase
	end

	// Gather bytes, pad, hand blocks to the compression, hold the digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			ret_q   <= T_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			obusy_q <= 1'b0;
			part_q  <= '0;
			dig_q   <= '0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						if (byte_in.byte_valid) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (byte_in.byte_valid && fill_q == LAST_FILL) begin
							state_q <= T_START;
							ret_q   <= byte_in.message_end ? T_PAD80 : T_IDLE;
						end else if (byte_in.message_end) begin
							state_q <= T_PAD80;
						end
					end
				end
				T_PAD80: begin
					fill_q  <= fill_q + 6'd1;
					ret_q   <= T_ZERO;
					state_q <= (fill_q == LAST_FILL) ? T_START : T_ZERO;
				end
				T_ZERO: begin
					if (fill_q == LEN_POS) begin
						state_q <= T_LEN;
					end else begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == LAST_FILL) begin
							ret_q   <= T_ZERO;
							state_q <= T_START;
						end
					end
				end
				T_LEN: begin
					fill_q <= fill_q + 6'd1;
					bits_q <= {bits_q[55:0], bits_q[63:56]};
					if (fill_q == LAST_FILL) begin
						ret_q   <= T_DIGEST;
						state_q <= T_START;
					end
				end
				T_START:  state_q <= T_WAIT;
				T_WAIT: begin
					if (stat.done) begin
						state_q <= ret_q;
					end
				end
				T_DIGEST: begin
					if (!obusy_q) begin
						dig_q   <= hash;
						obusy_q <= 1'b1;
						part_q  <= '0;
						bits_q  <= '0;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase

			// Drain the digest one part per beat
			if (out_acc) begin
				if (part_q == 2'd3) begin
					obusy_q <= 1'b0;
				end else begin
					part_q <= part_q + 2'd1;
				end
			end
		end
	end

	assign digest_out.valid       = obusy_q;
	assign digest_out.digest_part = dig_q[part_q];
	assign digest_out.part_index  = part_q;
	assign digest_out.last_part   = (part_q == 2'd3);

	`SBH_ASSERT_IMPLY(a_no_take_while_busy, stat.busy, !byte_in.ready)
	`SBH_ASSERT_IMPLY(a_block_full_at_start, state_q == T_START, fill_q == '0)
	`SBH_ASSERT_NEXT(a_part_advance, out_acc && part_q != 2'd3, part_q == $past(part_q) + 2'd1)
	`SBH_ASSERT_NEXT(a_digest_load, state_q == T_DIGEST && !obusy_q, obusy_q && part_q == 2'd0)

endmodule

FILE: tb/sv/sha256_digest_checker.sv
// Checker for the SHA-256 byte stream hasher: predicts digest parts and compares each beat.
module sha256_digest_checker (
	input  logic         clk,
	input  logic         arst_n,
	sha256_bsh_byte_if   byte_ch,
	sha256_bsh_digest_if digest_ch,
	output int           fail_count,
	output int           parts_due
);

	localparam int REPORT_LIMIT = 10;

	localparam logic [31:0] CHAIN_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef struct packed {
		logic [63:0] part;
		logic [1:0]  index;
		logic        last;
	} digest_beat_t;

	// Expected digest parts, oldest first
	digest_beat_t digest_parts_due [$];

	// Predicted hasher state
	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	logic [6:0]  fill;
	logic [63:0] bit_len;
	int          mismatch_count;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	// Run the 64 rounds over the held block and fold into the chaining words
	function automatic void compress_block();
		logic [31:0] sched [64];
		logic [31:0] wv [8];
		logic [31:0] t1;
		logic [31:0] t2;
		for (int i = 0; i < 16; i++)
			sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			sched[i] = sched[i-16] + sched[i-7]
				+ (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
				+ (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			wv[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
				+ ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_K[i] + sched[i];
			t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
				+ ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
			wv[7] = wv[6];
			wv[6] = wv[5];
			wv[5] = wv[4];
			wv[4] = wv[3] + t1;
			wv[3] = wv[2];
			wv[2] = wv[1];
			wv[1] = wv[0];
			wv[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + wv[i];
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = CHAIN_IV[i];
		fill = '0;
		bit_len = '0;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		blk[fill[5:0]] = b;
		fill = fill + 7'd1;
	endfunction

	// Absorb one input beat; on message end pad, finish and queue four digest parts
	function automatic void hash_item(input logic [7:0] b, input logic bv, input logic me);
		digest_beat_t beat;
		if (bv) begin
			put_byte(b);
			bit_len = bit_len + 64'd8;
			if (fill == 7'd64) begin
				compress_block();
				fill = '0;
			end
		end
		if (me) begin
			put_byte(8'h80);
			// no room for the length: close this block with zeros first
			if (fill > 7'd56) begin
				while (fill < 7'd64)
					put_byte(8'h00);
				compress_block();
				fill = '0;
			end
			while (fill < 7'd56)
				put_byte(8'h00);
			for (int k = 0; k < 8; k++)
				put_byte(bit_len[63-8*k -: 8]);
			compress_block();
			for (int k = 0; k < 4; k++) begin
				beat.part  = {chain[2*k], chain[2*k+1]};
				beat.index = 2'(k);
				beat.last  = (k == 3);
				digest_parts_due.push_back(beat);
			end
			restart_message();
		end
	endfunction

	// Track input beats and compare digest beats against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t want;
		if (!arst_n) begin
			restart_message();
			digest_parts_due.delete();
			mismatch_count = 0;
			fail_count <= 0;
			parts_due <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				hash_item(byte_ch.msg_byte, byte_ch.byte_valid, byte_ch.message_end);
			if (digest_ch.valid && digest_ch.ready) begin
				if (digest_parts_due.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("digest beat with nothing expected: part %h index %0d last %0b",
							digest_ch.digest_part, digest_ch.part_index, digest_ch.last_part);
					mismatch_count++;
				end else begin
					want = digest_parts_due.pop_front();
					if (digest_ch.digest_part !== want.part || digest_ch.part_index !== want.index
						|| digest_ch.last_part !== want.last) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
								want.part, want.index, want.last, digest_ch.digest_part,
								digest_ch.part_index, digest_ch.last_part);
						mismatch_count++;
					end
				end
			end
			fail_count <= mismatch_count;
			parts_due <= digest_parts_due.size();
		end
	end

endmodule

FILE: tb/sv/sha256_byte_stream_hasher_unit_tb.sv
// Testbench top for the SHA-256 byte stream hasher: clock, reset, stimulus and verdict.
module sha256_byte_stream_hasher_unit_tb;

	localparam int ITEM_TARGET   = 360;
	localparam int SETTLE_CYCLES = 400;
	localparam int RUN_LIMIT     = 400000;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PULSE, RX_LONG} rx_mode_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     rx_ready = 1'b0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_phase_left = 0;
	int       rx_hold = 0;
	logic [1:0] rx_tick = '0;
	int       burst_left = 0;
	int       items_sent = 0;
	int       fail_count;
	int       parts_due;

	sha256_bsh_byte_if   byte_ch ();
	sha256_bsh_digest_if digest_ch ();

	assign digest_ch.ready = rx_ready;

	sha256_byte_stream_hasher_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.digest_out (digest_ch)
	);

	sha256_digest_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.digest_ch  (digest_ch),
		.fail_count (fail_count),
		.parts_due  (parts_due)
	);

	always #1 clk = ~clk;

	// Receiver back-pressure: switch between open, coin-flip, pulsed and long-stall phases
	always @(negedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_phase_left <= $urandom_range(50, 300);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		rx_tick <= rx_tick + 2'd1;
		case (rx_mode)
			RX_OPEN: begin
				rx_ready <= 1'b1;
			end
			RX_COIN: begin
				rx_ready <= 1'($urandom_range(0, 1));
			end
			RX_PULSE: begin
				rx_ready <= (rx_tick == 2'd0);
			end
			default: begin
				if (rx_hold == 0) begin
					rx_ready <= ~rx_ready;
					rx_hold <= $urandom_range(0, 20);
				end else begin
					rx_hold <= rx_hold - 1;
				end
			end
		endcase
	end

	// Drive one beat at the falling edge, hold it until taken; insert gaps between bursts
	task automatic drive_beat(input logic [7:0] b, input logic bv, input logic me);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				byte_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		byte_ch.valid       = 1'b1;
		byte_ch.msg_byte    = b;
		byte_ch.byte_valid  = bv;
		byte_ch.message_end = me;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Send a message of random bytes with occasional empty beats mixed in
	task automatic send_message(input int len);
		logic ride;
		ride = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				drive_beat(8'($urandom), 1'b0, 1'b0);
				items_sent++;
			end
			drive_beat(8'($urandom), 1'b1, ride && (i == len - 1));
			items_sent++;
		end
		if (!ride) begin
			drive_beat(8'($urandom), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	initial begin
		byte_ch.valid       = 1'b0;
		byte_ch.msg_byte    = '0;
		byte_ch.byte_valid  = 1'b0;
		byte_ch.message_end = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: ignored beat, empty message, single bytes with end, short messages
		drive_beat(8'hff, 1'b0, 1'b0);
		drive_beat(8'h00, 1'b0, 1'b1);
		drive_beat(8'h00, 1'b1, 1'b1);
		drive_beat(8'hff, 1'b1, 1'b1);
		drive_beat(8'h61, 1'b1, 1'b0);
		drive_beat(8'h62, 1'b1, 1'b0);
		drive_beat(8'h63, 1'b1, 1'b1);
		drive_beat(8'h80, 1'b1, 1'b0);
		drive_beat(8'ha5, 1'b0, 1'b0);
		drive_beat(8'h7f, 1'b1, 1'b0);
		drive_beat(8'hff, 1'b0, 1'b1);
		drive_beat(8'h5a, 1'b0, 1'b1);
		drive_beat(8'h01, 1'b1, 1'b0);
		drive_beat(8'hfe, 1'b1, 1'b1);
		items_sent = 14;

		// Random: padding boundaries first, then mostly short messages
		send_message(55);
		send_message(56);
		send_message(63);
		send_message(64);
		while (items_sent < ITEM_TARGET)
			send_message(($urandom_range(0, 7) == 0) ? $urandom_range(50, 70)
				: $urandom_range(0, 20));
		byte_ch.valid = 1'b0;

		// Drain outstanding digests, then watch for strays
		while (parts_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sha256_byte_stream_hasher_unit verification clean");
		else
			$display("sha256_byte_stream_hasher_unit verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#RUN_LIMIT;
		$display("sha256_byte_stream_hasher_unit verification failed");
		$finish;
	end

endmodule
